@@ design/clapd_pkg.sv @@
// ----------------------------------------------------------------------------
// clapd_pkg
// shared widths, codes and types of the clap pattern detector
// ----------------------------------------------------------------------------
`default_nettype none

package clapd_pkg;

  // samples per analysis window (1 to 128)
  localparam int WINDOW = 70;

  localparam int SAMPLE_W = 10;
  localparam int TIME_W   = 32;
  localparam int GAP_W    = 16;
  localparam int IDX_W    = 7;
  localparam int COUNT_W  = 8;
  localparam int PAT_W    = 2;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // queue between window tracker and decision stage
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AMP_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_GAP       = 2'd2;

  // register reset values
  localparam logic [SAMPLE_W-1:0] AMP_THRESHOLD_RST = 10'd512;
  localparam logic [GAP_W-1:0]    MIN_GAP_RST       = 16'd100;
  localparam logic [GAP_W-1:0]    END_GAP_RST       = 16'd700;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [PAT_W-1:0] {
    PAT_NONE   = 2'd0,
    PAT_DOUBLE = 2'd1,
    PAT_TRIPLE = 2'd2
  } pattern_t;

  // one finished window handed from front to back
  typedef struct packed {
    logic [SAMPLE_W-1:0] amp;
    logic [TIME_W-1:0]   now_ms;
  } win_entry_t;

  // configuration seen by the decision stage
  typedef struct packed {
    logic [SAMPLE_W-1:0] amp_threshold;
    logic [GAP_W-1:0]    min_gap_ms;
    logic [GAP_W-1:0]    end_gap_ms;
  } cfg_t;

  // queue status toward the producer and consumer
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

@@ design/clap_pattern_detector_top.sv @@
// ----------------------------------------------------------------------------
// clap_pattern_detector_top
// peak-to-peak clap detector, double/triple clap pattern classification
// ----------------------------------------------------------------------------
// throughput: one sample per cycle unless a window's last sample finds the queue
//   full; the window tracker updates min/max on each accepted sample, and the
//   decision stage retires one window per cycle unless the result is stalled
// result path: the window's last sample is written into the queue, then the
//   decision for that window is registered into the output register
// reset: synchronous, clears window, tally, pattern, queue and the registers
//   to their defaults (threshold 512, min gap 100, end gap 700); no clearing pass
`default_nettype none

module clap_pattern_detector_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // sample channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [clapd_pkg::SAMPLE_W-1:0]      sample,
  input  wire logic [clapd_pkg::TIME_W-1:0]        now_ms,
  // result channel, one transfer per finished window
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [clapd_pkg::PAT_W-1:0]              pattern,
  output logic [clapd_pkg::COUNT_W-1:0]            clap_count,
  output logic [clapd_pkg::SAMPLE_W-1:0]           amplitude,
  // register write port
  input  wire logic                                cfg_we,
  input  wire logic [clapd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [clapd_pkg::CFG_W-1:0]         cfg_wdata
);

  clapd_pkg::cfg_t       cfg;
  clapd_pkg::q_status_t  q_status;
  clapd_pkg::win_entry_t push_entry;
  clapd_pkg::win_entry_t pop_entry;
  logic                  push;
  logic                  pop;

  // configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.amp_threshold <= clapd_pkg::AMP_THRESHOLD_RST;
      cfg.min_gap_ms    <= clapd_pkg::MIN_GAP_RST;
      cfg.end_gap_ms    <= clapd_pkg::END_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        clapd_pkg::REG_AMP_THRESHOLD: begin
          cfg.amp_threshold <= cfg_wdata[clapd_pkg::SAMPLE_W-1:0];
        end
        clapd_pkg::REG_MIN_GAP: begin
          cfg.min_gap_ms <= cfg_wdata[clapd_pkg::GAP_W-1:0];
        end
        clapd_pkg::REG_END_GAP: begin
          cfg.end_gap_ms <= cfg_wdata[clapd_pkg::GAP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // front: min/max tracking, window end produces an amplitude entry
  clapd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .now_ms     (now_ms),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  // short queue lets sample intake continue while a result is stalled
  clapd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_status   (q_status)
  );

  // back: gap evaluation, clap tally, pattern, registered result
  clapd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_status   (q_status),
    .pop_entry  (pop_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pattern    (pattern),
    .clap_count (clap_count),
    .amplitude  (amplitude)
  );

endmodule

`default_nettype wire

@@ design/clapd_front.sv @@
// ----------------------------------------------------------------------------
// clapd_front
// window tracker: min/max over a window, emits amplitude at window end
// ----------------------------------------------------------------------------
`default_nettype none

module clapd_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [clapd_pkg::SAMPLE_W-1:0]     sample,
  input  wire logic [clapd_pkg::TIME_W-1:0]       now_ms,
  input  wire clapd_pkg::q_status_t               q_status,
  output logic                                    push,
  output clapd_pkg::win_entry_t                   push_entry
);

  logic [clapd_pkg::SAMPLE_W-1:0] win_max;
  logic [clapd_pkg::SAMPLE_W:0]   win_min;
  logic [clapd_pkg::IDX_W-1:0]    sample_index;

  logic                           last;
  logic                           accept;
  logic [clapd_pkg::SAMPLE_W-1:0] max_next;
  logic [clapd_pkg::SAMPLE_W:0]   min_next;

  assign last = (sample_index == clapd_pkg::IDX_W'(clapd_pkg::WINDOW - 1));

  // only the window's last sample needs room in the queue
  assign in_ready = !(last && q_status.full);
  assign accept   = in_valid && in_ready;

  assign max_next = (sample > win_max) ? sample : win_max;
  assign min_next = ({1'b0, sample} < win_min) ? {1'b0, sample} : win_min;

  assign push              = accept && last;
  assign push_entry.amp    = max_next - min_next[clapd_pkg::SAMPLE_W-1:0];
  assign push_entry.now_ms = now_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_max      <= '0;
      win_min      <= (clapd_pkg::SAMPLE_W+1)'(1 << clapd_pkg::SAMPLE_W);
      sample_index <= '0;
    end else if (accept) begin
      if (last) begin
        win_max      <= '0;
        win_min      <= (clapd_pkg::SAMPLE_W+1)'(1 << clapd_pkg::SAMPLE_W);
        sample_index <= '0;
      end else begin
        win_max      <= max_next;
        win_min      <= min_next;
        sample_index <= sample_index + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/clapd_queue.sv @@
// ----------------------------------------------------------------------------
// clapd_queue
// short register queue of finished windows
// ----------------------------------------------------------------------------
`default_nettype none

module clapd_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire clapd_pkg::win_entry_t push_entry,
  input  wire logic                  pop,
  output clapd_pkg::win_entry_t      pop_entry,
  output clapd_pkg::q_status_t       q_status
);

  clapd_pkg::win_entry_t             slots [clapd_pkg::Q_DEPTH];
  logic [clapd_pkg::Q_PTR_W-1:0]     wr_ptr;
  logic [clapd_pkg::Q_PTR_W-1:0]     rd_ptr;
  logic [clapd_pkg::Q_CNT_W-1:0]     count;

  assign q_status.full  = (count == clapd_pkg::Q_CNT_W'(clapd_pkg::Q_DEPTH));
  assign q_status.empty = (count == '0);
  assign pop_entry      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == clapd_pkg::Q_PTR_W'(clapd_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == clapd_pkg::Q_PTR_W'(clapd_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/clapd_back.sv @@
// ----------------------------------------------------------------------------
// clapd_back
// decision stage: gap check, clap tally, pattern, output register
// ----------------------------------------------------------------------------
`default_nettype none

module clapd_back (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire clapd_pkg::cfg_t                    cfg,
  input  wire clapd_pkg::q_status_t               q_status,
  input  wire clapd_pkg::win_entry_t              pop_entry,
  output logic                                    pop,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [clapd_pkg::PAT_W-1:0]             pattern,
  output logic [clapd_pkg::COUNT_W-1:0]           clap_count,
  output logic [clapd_pkg::SAMPLE_W-1:0]          amplitude
);

  logic [clapd_pkg::TIME_W-1:0]   last_loud_ms;
  logic [clapd_pkg::COUNT_W-1:0]  clap_tally;
  clapd_pkg::pattern_t            pattern_state;
  clapd_pkg::pattern_t            pattern_out;
  logic [clapd_pkg::SAMPLE_W-1:0] amp_out;

  logic [clapd_pkg::TIME_W-1:0]   diff;
  logic [clapd_pkg::GAP_W-1:0]    gap;
  logic                           loud;
  logic                           clap;
  logic [clapd_pkg::COUNT_W-1:0]  tally_mid;
  logic [clapd_pkg::COUNT_W-1:0]  clap_tally_next;
  clapd_pkg::pattern_t            pattern_state_next;

  assign pop = !q_status.empty && (!out_valid || out_ready);

  assign diff = pop_entry.now_ms - last_loud_ms;
  assign gap  = diff[clapd_pkg::GAP_W-1:0];
  assign loud = (pop_entry.amp > cfg.amp_threshold);
  assign clap = loud && (gap > cfg.min_gap_ms);

  always_comb begin
    tally_mid          = clap_tally;
    pattern_state_next = pattern_state;
    if (gap > cfg.end_gap_ms) begin
      if (clap_tally != '0) begin
        if (clap_tally == clapd_pkg::COUNT_W'(2)) begin
          pattern_state_next = clapd_pkg::PAT_DOUBLE;
        end
        if (clap_tally == clapd_pkg::COUNT_W'(3)) begin
          pattern_state_next = clapd_pkg::PAT_TRIPLE;
        end
        tally_mid = '0;
      end else begin
        pattern_state_next = clapd_pkg::PAT_NONE;
      end
    end
    clap_tally_next = tally_mid;
    if (clap && (tally_mid != clapd_pkg::COUNT_MAX)) begin
      clap_tally_next = tally_mid + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_loud_ms  <= '0;
      clap_tally    <= '0;
      pattern_state <= clapd_pkg::PAT_NONE;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        if (loud) begin
          last_loud_ms <= pop_entry.now_ms;
        end
        clap_tally    <= clap_tally_next;
        pattern_state <= pattern_state_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pattern_out <= pattern_state_next;
      amp_out     <= pop_entry.amp;
    end
  end

  assign pattern    = pattern_out;
  assign clap_count = clap_tally;
  assign amplitude  = amp_out;

  // pattern code three is never produced
  a_no_pattern_three: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pattern != 2'd3))
    else $error("pattern code three on output");

  // tally moves only when a window is decided
  a_tally_on_pop: assert property (@(posedge clk) disable iff (rst)
    !pop |=> $stable(clap_tally))
    else $error("clap tally changed without a window");

  // a new result follows a pop from the queue
  a_valid_from_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pop))
    else $error("result appeared without a queued window");

endmodule

`default_nettype wire
